FILE: rtl/core/rip_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the radix integer parser.
// Used by rip_front, rip_back and radix_integer_parser_top; depends on nothing.
package rip_pkg;

    // Field widths of the ports
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned RADIX_W    = 6;
    localparam int unsigned WSEL_W     = 2;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned DIGIT_W    = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;
    // Product of the accumulator and the radix, plus one digit
    localparam int unsigned PROD_W     = VALUE_W + RADIX_W;

    // Default saturation point of the consumed count
    localparam logic [31:0] COUNT_LIMIT_DEF = 32'd65535;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WSEL   = 2'd2;

    // Register values after reset
    localparam logic [RADIX_W-1:0] RADIX_RST  = 6'd10;
    localparam logic               SIGNED_RST = 1'b1;
    localparam logic [WSEL_W-1:0]  WSEL_RST   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // Type width codes
    localparam logic [WSEL_W-1:0] WSEL_8  = 2'd0;
    localparam logic [WSEL_W-1:0] WSEL_16 = 2'd1;
    localparam logic [WSEL_W-1:0] WSEL_32 = 2'd2;
    localparam logic [WSEL_W-1:0] WSEL_64 = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] NOT_DIGIT  = 8'd255;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // Live configuration
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               sign_mode;
        logic [WSEL_W-1:0]  width_select;
    } t_cfg;

    // One classified character, as passed from the front to the back
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               is_digit;
        logic               is_minus;
        logic               last;
    } t_item;

    // Snapshot of a finished string, waiting to be formatted
    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic               minus;
        logic               ovf;
        logic [COUNT_W-1:0] count;
        logic               sign_mode;
        logic [WSEL_W-1:0]  width_select;
    } t_fin;

    // One result item
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  consumed;
    } t_result;

    // Digit value of a character, or NOT_DIGIT
    function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] d;
        d = NOT_DIGIT;
        if (ch >= CHAR_0 && ch <= CHAR_9) begin
            d = ch - CHAR_0;
        end else if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
            d = ch - CHAR_UA + LETTER_OFS;
        end else if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
            d = ch - CHAR_LA + LETTER_OFS;
        end
        return d;
    endfunction

    // Radix clamped into 2..36
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        e = r;
        if (r < RADIX_MIN) begin
            e = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            e = RADIX_MAX;
        end
        return e;
    endfunction

    // Largest unsigned value of the selected type
    function automatic logic [VALUE_W-1:0] type_umax(input logic [WSEL_W-1:0] wsel);
        logic [VALUE_W-1:0] m;
        unique case (wsel)
            WSEL_8:  m = 64'h0000_0000_0000_00FF;
            WSEL_16: m = 64'h0000_0000_0000_FFFF;
            WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
            WSEL_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/rip_front.sv
`timescale 1ns / 1ps
// Front end of the radix integer parser: takes characters, classifies them
// and holds them in a two-entry queue for the back end. Depends on rip_pkg.
module rip_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [rip_pkg::CHAR_W-1:0]   i_character,
    input  logic                         i_last,
    input  rip_pkg::t_cfg                i_cfg,
    output logic                         o_item_valid,
    output rip_pkg::t_item               o_item,
    input  logic                         i_item_pop
);
    import rip_pkg::*;

    t_item             w_item;
    logic [CHAR_W-1:0] w_digit;
    logic              w_push_ok;
    logic              w_pop_ok;

    t_item             r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;

    // Classify the incoming character against the live radix.
    always_comb begin
        w_digit         = digit_of(i_character);
        w_item.digit    = w_digit[DIGIT_W-1:0];
        w_item.is_digit = (w_digit < {2'b00, eff_radix(i_cfg.radix)});
        w_item.is_minus = (i_character == CHAR_MINUS);
        w_item.last     = i_last;
    end

    // Queue handshakes.
    assign full         = (r_cnt == 2'd2);
    assign w_push_ok    = push && !full;
    assign o_item_valid = (r_cnt != 2'd0);
    assign w_pop_ok     = i_item_pop && o_item_valid;
    assign o_item       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push_ok && !w_pop_ok) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Queue storage; the entries carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= w_item;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wp <= ~r_wp;
            end
            if (w_pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/rip_back.sv
`timescale 1ns / 1ps
// Back end of the radix integer parser: per-string accumulator with the
// overflow check, result formatting and the result queue. Depends on rip_pkg.
module rip_back #(
    parameter logic [31:0] COUNT_LIMIT = rip_pkg::COUNT_LIMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rip_pkg::t_cfg                  i_cfg,
    input  logic                           i_item_valid,
    input  rip_pkg::t_item                 i_item,
    output logic                           o_item_pop,
    output logic                           empty,
    input  logic                           pop,
    output logic [rip_pkg::VALUE_W-1:0]    o_value,
    output logic [rip_pkg::STATUS_W-1:0]   o_status,
    output logic [rip_pkg::COUNT_W-1:0]    o_consumed
);
    import rip_pkg::*;

    localparam logic [COUNT_W-1:0] CountCap =
        (COUNT_LIMIT > 32'd65535) ? 16'hFFFF : COUNT_LIMIT[COUNT_W-1:0];

    // String state
    logic               r_at_start, n_at_start;
    logic               r_minus,    n_minus;
    logic [VALUE_W-1:0] r_acc,      n_acc;
    logic               r_ovf,      n_ovf;
    logic               r_stopped,  n_stopped;
    logic [COUNT_W-1:0] r_count,    n_count;

    // Finished string and result queue
    logic               r_fin_valid;
    t_fin               r_fin;
    t_fin               w_fin;
    t_result            r_oq [2];
    logic               r_owp;
    logic               r_orp;
    logic [1:0]         r_out_cnt;

    logic               w_take;
    logic               w_fin_move;
    logic               w_oq_pop;
    logic               w_sgn;
    logic               w_neg;
    logic [RADIX_W-1:0] w_r;
    logic [VALUE_W-1:0] w_umax;
    logic [VALUE_W-1:0] w_limit;
    logic [PROD_W-1:0]  w_next;
    logic               w_fits;
    logic [COUNT_W-1:0] w_bumped;
    t_result            w_res;

    // Handshakes between the accumulator, the finish stage and the result queue.
    assign w_oq_pop   = pop && !empty;
    assign w_fin_move = r_fin_valid && ((r_out_cnt != 2'd2) || w_oq_pop);
    assign w_take     = i_item_valid && !(i_item.last && r_fin_valid && !w_fin_move);
    assign o_item_pop = w_take;

    // One multiply-add step and its check against the type limit.
    always_comb begin
        w_sgn    = i_cfg.sign_mode;
        w_neg    = w_sgn && r_minus;
        w_r      = eff_radix(i_cfg.radix);
        w_umax   = type_umax(i_cfg.width_select);
        if (!w_sgn) begin
            w_limit = w_umax;
        end else if (w_neg) begin
            w_limit = (w_umax >> 1) + 64'd1;
        end else begin
            w_limit = w_umax >> 1;
        end
        w_next   = PROD_W'(r_acc) * PROD_W'(w_r) + PROD_W'(i_item.digit);
        w_fits   = (w_next <= PROD_W'(w_limit));
        w_bumped = (r_count < CountCap) ? (r_count + 16'd1) : r_count;
    end

    // Next string state, and the snapshot taken at the last character.
    always_comb begin
        n_at_start = r_at_start;
        n_minus    = r_minus;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        n_stopped  = r_stopped;
        n_count    = r_count;
        if (w_take && !r_stopped) begin
            if (r_at_start && w_sgn && i_item.is_minus) begin
                n_minus = 1'b1;
                n_count = w_bumped;
            end else if (!i_item.is_digit) begin
                n_stopped = 1'b1;
            end else begin
                if (w_fits) begin
                    n_acc = w_next[VALUE_W-1:0];
                end else begin
                    n_ovf = 1'b1;
                end
                n_count = w_bumped;
            end
            n_at_start = 1'b0;
        end
        w_fin.acc          = n_acc;
        w_fin.minus        = n_minus;
        w_fin.ovf          = n_ovf;
        w_fin.count        = n_count;
        w_fin.sign_mode    = w_sgn;
        w_fin.width_select = i_cfg.width_select;
        // The last character ends the string and starts a new one.
        if (w_take && i_item.last) begin
            n_at_start = 1'b1;
            n_minus    = 1'b0;
            n_acc      = '0;
            n_ovf      = 1'b0;
            n_stopped  = 1'b0;
            n_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_minus    <= 1'b0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_stopped  <= 1'b0;
            r_count    <= '0;
        end else begin
            r_at_start <= n_at_start;
            r_minus    <= n_minus;
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_stopped  <= n_stopped;
            r_count    <= n_count;
        end
    end

    // Finish stage: holds one completed string until the result queue has room.
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.last) begin
            r_fin <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_take && i_item.last) begin
            r_fin_valid <= 1'b1;
        end else if (w_fin_move) begin
            r_fin_valid <= 1'b0;
        end
    end

    // Format the finished string: negate, sign-extend, or report an error.
    always_comb begin
        logic [VALUE_W-1:0] fumax;
        logic [VALUE_W-1:0] v;
        logic               sbit;
        fumax = type_umax(r_fin.width_select);
        v     = r_fin.acc & fumax;
        if (r_fin.sign_mode && r_fin.minus) begin
            v = (64'd0 - v) & fumax;
        end
        unique case (r_fin.width_select)
            WSEL_8:  sbit = v[7];
            WSEL_16: sbit = v[15];
            WSEL_32: sbit = v[31];
            default: sbit = 1'b0;
        endcase
        if (r_fin.sign_mode && sbit) begin
            v = v | ~fumax;
        end
        if (r_fin.count == {{(COUNT_W-1){1'b0}}, r_fin.minus}) begin
            w_res.value    = '0;
            w_res.status   = ST_INVALID;
            w_res.consumed = '0;
        end else if (r_fin.ovf) begin
            w_res.value    = '0;
            w_res.status   = ST_RANGE;
            w_res.consumed = r_fin.count;
        end else begin
            w_res.value    = v;
            w_res.status   = ST_OK;
            w_res.consumed = r_fin.count;
        end
    end

    // Result queue of two entries, so that a waiting result does not block the
    // next string.
    always_ff @(posedge i_clk) begin
        if (w_fin_move) begin
            r_oq[r_owp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp     <= 1'b0;
            r_orp     <= 1'b0;
            r_out_cnt <= 2'd0;
        end else begin
            if (w_fin_move) begin
                r_owp <= ~r_owp;
            end
            if (w_oq_pop) begin
                r_orp <= ~r_orp;
            end
            if (w_fin_move && !w_oq_pop) begin
                r_out_cnt <= r_out_cnt + 2'd1;
            end else if (!w_fin_move && w_oq_pop) begin
                r_out_cnt <= r_out_cnt - 2'd1;
            end
        end
    end

    assign empty      = (r_out_cnt == 2'd0);
    assign o_value    = r_oq[r_orp].value;
    assign o_status   = r_oq[r_orp].status;
    assign o_consumed = r_oq[r_orp].consumed;

    // The result queue never holds more than its two entries.
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt != 2'd3)
        else $error("result queue overfilled");

    // A finished string that cannot move on is held unchanged.
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && !w_fin_move) |=> (r_fin_valid && $stable(r_fin)))
        else $error("finished string lost while stalled");

    // An invalid result reports neither a value nor a count.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_INVALID) |-> (o_value == '0 && o_consumed == '0))
        else $error("invalid result carries a value or count");

    // An out-of-range result reports a zero value.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_RANGE) |-> (o_value == '0))
        else $error("out-of-range result carries a value");

endmodule

FILE: rtl/core/radix_integer_parser_top.sv
`timescale 1ns / 1ps
// Top level of the radix integer parser: configuration registers and the
// front and back ends. Depends on rip_pkg, rip_front and rip_back.
//
// The parser takes one character per clock cycle through the push/full
// queue interface and gives one result per string, at the character marked
// last, through the empty/pop interface. Characters flow at one per cycle
// without gaps while results are taken; a result becomes visible once its
// last character has passed the front queue, the finish stage and the result
// queue, all three registered. The accumulator does one 64-by-6-bit
// multiply-add and limit compare per character. Up to three results may wait
// (two in the result queue, one in the finish stage); a further last character
// then stalls in the back end, and the input fills once the two-entry front
// queue behind it is occupied. Configuration writes are always accepted and
// should be made only while no character or result is in flight; they then
// apply from the next character.
module radix_integer_parser_top #(
    parameter logic [31:0] COUNT_LIMIT = rip_pkg::COUNT_LIMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [rip_pkg::CHAR_W-1:0]     i_character,
    input  logic                           i_last,
    output logic                           empty,
    input  logic                           pop,
    output logic [rip_pkg::VALUE_W-1:0]    o_value,
    output logic [rip_pkg::STATUS_W-1:0]   o_status,
    output logic [rip_pkg::COUNT_W-1:0]    o_consumed,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rip_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rip_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rip_pkg::*;

    t_cfg  r_cfg;
    t_item w_item;
    logic  w_item_valid;
    logic  w_item_pop;

    // Configuration writes are taken in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix        <= RADIX_RST;
            r_cfg.sign_mode    <= SIGNED_RST;
            r_cfg.width_select <= WSEL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RADIX:  r_cfg.radix        <= i_cfg_data[RADIX_W-1:0];
                CFG_SIGNED: r_cfg.sign_mode    <= i_cfg_data[0];
                CFG_WSEL:   r_cfg.width_select <= i_cfg_data[WSEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rip_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_character  (i_character),
        .i_last       (i_last),
        .i_cfg        (r_cfg),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    rip_back #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .empty        (empty),
        .pop          (pop),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_consumed   (o_consumed)
    );

endmodule
